// ===== rtl/ntoh_pkg.sv =====
// Shared constants and types for the note timing offset humaniser.
package ntoh_pkg;

    // Configuration register indexes and style codes.
    localparam logic REG_STYLE  = 1'b0;
    localparam logic REG_AMOUNT = 1'b1;

    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_HUMAN = 2'd1;
    localparam logic [1:0] MODE_SWING = 2'd2;

    // Field widths.
    localparam int AMOUNT_W = 10;
    localparam int PERIOD_W = 16;
    localparam int OFFSET_W = 15;
    localparam int SUM_W    = 10;
    localparam int SIGMA_W  = 5;

    // Shared unit widths: 27 x 26 signed multiply.
    localparam int MUL_A_W = 27;
    localparam int MUL_B_W = 26;
    localparam int ACC_W   = MUL_A_W + MUL_B_W;

    // Sigma is amount x 26 / 1000, taken as amount x 1704 shifted right by 16.
    // This gives the exact floor for every ten-bit amount.
    localparam logic [MUL_B_W-1:0] SIGMA_RECIP = 26'd1704;
    localparam int                 SIGMA_SHIFT = 16;

    // Swing: amount x 17 fits TERM_W bits and that times the period fits
    // PRODUCT_W bits. Division by 100000 is a shift right by PRE_SHIFT, then a
    // multiply by 2^36 / 3125 rounded up and a shift right by RECIP_SHIFT,
    // which gives the exact floor over that whole range.
    localparam logic [MUL_B_W-1:0] SWING_SCALE = 26'd17;
    localparam int                 TERM_W      = 15;
    localparam int                 PRODUCT_W   = 31;
    localparam int                 PRE_SHIFT   = 5;
    localparam logic [MUL_B_W-1:0] SWING_RECIP = 26'd21990233;
    localparam int                 RECIP_SHIFT = 36;
    localparam int                 QUO_W       = 14;

    localparam logic [AMOUNT_W-1:0] AMOUNT_MIN  = 10'd10;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    // Operands presented to the shared arithmetic unit.
    typedef struct packed {
        logic signed [MUL_A_W-1:0] mul_a;
        logic signed [MUL_B_W-1:0] mul_b;
    } alu_in_t;

    // Results returned by the shared arithmetic unit.
    typedef struct packed {
        logic signed [ACC_W-1:0] prod;
    } alu_out_t;

endpackage

// ===== rtl/ntoh_lfsr.sv =====
// Sixteen-bit right-shifting Galois LFSR that yields one byte per step.
module ntoh_lfsr
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    output logic [7:0] byte_out
);

    logic [15:0] lfsr_reg;
    logic [15:0] lfsr_next;
    logic [15:0] shifted;

    // The byte offered is the low byte of the value after the coming step.
    always_comb
    begin
        shifted = {1'b0, lfsr_reg[15:1]};
        if (lfsr_reg[0])
        begin
            shifted = shifted ^ ntoh_pkg::LFSR_TAPS;
        end
        lfsr_next = step ? shifted : lfsr_reg;
        byte_out  = shifted[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= ntoh_pkg::LFSR_SEED;
        end
        else
        begin
            lfsr_reg <= lfsr_next;
        end
    end

endmodule

// ===== rtl/ntoh_alu.sv =====
// Shared arithmetic unit: one signed multiplier.
module ntoh_alu
(
    input  ntoh_pkg::alu_in_t  alu_in,
    output ntoh_pkg::alu_out_t alu_out
);

    always_comb
    begin
        alu_out.prod = alu_in.mul_a * alu_in.mul_b;
    end

endmodule

// ===== rtl/note_timing_offset_humanizer_core.sv =====
// Top level of the note timing offset humaniser: sequencer, registers and ports.
//
// Each accepted item is one note step (odd_step in s_tuser, step_period in
// s_tdata) and gives one signed millisecond offset on m_tdata. The block takes
// one item at a time: s_tready is low from acceptance until the result has been
// loaded into the output register, which can still hold the previous result
// while the next item is being worked on. All arithmetic runs through a single
// shared 27 x 26 signed multiplier under a small sequencer, whose steps depend
// on the style. With the style off, or the amount below ten per mille, an item
// goes straight to the output step. In swing style the steps are amount times
// 17, that times the period, the division by 100000 as a shift and a multiply
// by a scaled reciprocal of 3125, a step to apply the sign and the output
// step. In human style sigma comes from one multiply by a scaled reciprocal of
// 1000, and the item goes straight to the output step when sigma is zero;
// otherwise four LFSR draws, the sigma multiply and a rounding step follow.
// The output step waits while the output register holds a stalled result.
// Configuration writes are to be made only while no item is in flight.
module note_timing_offset_humanizer_core
(
    input  logic        clk,
    input  logic        rst_n,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] step_period
    input  logic        s_tuser,    // [0] odd_step
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [14:0] offset, [15] zero
    // Configuration writes.
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [9:0]  cfg_wdata
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL_A = 3'd1;
    localparam logic [2:0] ST_MUL_P = 3'd2;
    localparam logic [2:0] ST_RECIP = 3'd3;
    localparam logic [2:0] ST_LFSR  = 3'd4;
    localparam logic [2:0] ST_MUL_H = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    // Configuration registers.
    logic [1:0]                    style_reg;
    logic [ntoh_pkg::AMOUNT_W-1:0] amount_reg;

    // Sequencer and working registers.
    logic [2:0]                        state_reg,  state_next;
    logic                              hum_reg,    hum_next;
    logic                              odd_reg,    odd_next;
    logic [ntoh_pkg::PERIOD_W-1:0]     period_reg, period_next;
    logic signed [ntoh_pkg::ACC_W-1:0] acc_reg,    acc_next;
    logic [1:0]                        cnt_reg,    cnt_next;
    logic [ntoh_pkg::SIGMA_W-1:0]      sigma_reg,  sigma_next;
    logic signed [ntoh_pkg::SUM_W-1:0] sum_reg,    sum_next;
    logic [ntoh_pkg::OFFSET_W-1:0]     res_reg,    res_next;

    // Output register.
    logic                            out_valid_reg, out_valid_next;
    logic [ntoh_pkg::OFFSET_W-1:0]   out_data_reg,  out_data_next;

    ntoh_pkg::alu_in_t  alu_in;
    ntoh_pkg::alu_out_t alu_out;

    logic                              lfsr_step;
    logic [7:0]                        lfsr_byte;
    logic [7:0]                        centred;
    logic [ntoh_pkg::SIGMA_W-1:0]      sigma_new;
    logic [ntoh_pkg::OFFSET_W-1:0]     quo_ext;
    logic signed [ntoh_pkg::ACC_W-1:0] hum_adj;
    logic signed [ntoh_pkg::ACC_W-1:0] hum_shift;
    logic                              in_accept;
    logic                              active;

    ntoh_alu u_alu
    (
        .alu_in  (alu_in),
        .alu_out (alu_out)
    );

    ntoh_lfsr u_lfsr
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (lfsr_step),
        .byte_out (lfsr_byte)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {1'b0, out_data_reg};

    // Styles only take effect from ten per mille upwards; code 3 acts as off.
    assign active = (amount_reg >= ntoh_pkg::AMOUNT_MIN);

    // Sigma straight from the amount multiply, and the swing magnitude from
    // the reciprocal multiply held in the accumulator.
    assign sigma_new = alu_out.prod[ntoh_pkg::SIGMA_SHIFT +: ntoh_pkg::SIGMA_W];
    assign quo_ext   = {1'b0, acc_reg[ntoh_pkg::RECIP_SHIFT +: ntoh_pkg::QUO_W]};

    // Byte minus 128 is the byte with its top bit flipped, read as signed.
    assign centred = lfsr_byte ^ 8'h80;

    // Division by 512 truncating toward zero: bias negative products.
    assign hum_adj   = acc_reg + (acc_reg[ntoh_pkg::ACC_W-1] ? ntoh_pkg::ACC_W'(511)
                                                             : ntoh_pkg::ACC_W'(0));
    assign hum_shift = hum_adj >>> 9;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        alu_in.mul_a = '0;
        alu_in.mul_b = '0;
        case (state_reg)
            ST_MUL_A:
            begin
                // Amount times the sigma reciprocal (human) or 17 (swing).
                alu_in.mul_a = signed'(ntoh_pkg::MUL_A_W'(amount_reg));
                alu_in.mul_b = signed'(hum_reg ? ntoh_pkg::SIGMA_RECIP
                                               : ntoh_pkg::SWING_SCALE);
            end

            ST_MUL_P:
            begin
                alu_in.mul_a = signed'(ntoh_pkg::MUL_A_W'(period_reg));
                alu_in.mul_b = signed'(ntoh_pkg::MUL_B_W'(acc_reg[ntoh_pkg::TERM_W-1:0]));
            end

            ST_RECIP:
            begin
                // The product divided by 32, times the reciprocal of 3125.
                alu_in.mul_a = signed'(ntoh_pkg::MUL_A_W'(
                    acc_reg[ntoh_pkg::PRODUCT_W-1:ntoh_pkg::PRE_SHIFT]));
                alu_in.mul_b = signed'(ntoh_pkg::SWING_RECIP);
            end

            ST_MUL_H:
            begin
                alu_in.mul_a = signed'({{(ntoh_pkg::MUL_A_W - ntoh_pkg::SUM_W){sum_reg[9]}},
                                        sum_reg});
                alu_in.mul_b = signed'(ntoh_pkg::MUL_B_W'(sigma_reg));
            end

            default:
            begin
                alu_in = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        hum_next       = hum_reg;
        odd_next       = odd_reg;
        period_next    = period_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        sigma_next     = sigma_reg;
        sum_next       = sum_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        lfsr_step      = 1'b0;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    odd_next    = s_tuser;
                    period_next = s_tdata;
                    hum_next    = (style_reg == ntoh_pkg::MODE_HUMAN);
                    res_next    = '0;
                    if (active && ((style_reg == ntoh_pkg::MODE_HUMAN) ||
                                   (style_reg == ntoh_pkg::MODE_SWING)))
                    begin
                        state_next = ST_MUL_A;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end

            ST_MUL_A:
            begin
                acc_next = alu_out.prod;
                if (hum_reg)
                begin
                    sigma_next = sigma_new;
                    sum_next   = '0;
                    cnt_next   = 2'd3;
                    if (sigma_new == '0)
                    begin
                        res_next   = '0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_LFSR;
                    end
                end
                else
                begin
                    state_next = ST_MUL_P;
                end
            end

            ST_MUL_P:
            begin
                acc_next   = alu_out.prod;
                state_next = ST_RECIP;
            end

            ST_RECIP:
            begin
                acc_next   = alu_out.prod;
                state_next = ST_FIN;
            end

            ST_LFSR:
            begin
                lfsr_step = 1'b1;
                sum_next  = sum_reg + signed'({{2{centred[7]}}, centred});
                cnt_next  = cnt_reg - 2'd1;
                if (cnt_reg == 2'd0)
                begin
                    state_next = ST_MUL_H;
                end
            end

            ST_MUL_H:
            begin
                acc_next   = alu_out.prod;
                state_next = ST_FIN;
            end

            ST_FIN:
            begin
                if (hum_reg)
                begin
                    res_next = hum_shift[ntoh_pkg::OFFSET_W-1:0];
                end
                else
                begin
                    // Even steps are pushed later, odd steps earlier.
                    res_next = odd_reg ? (~quo_ext + 15'd1) : quo_ext;
                end
                state_next = ST_OUT;
            end

            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            style_reg     <= ntoh_pkg::MODE_OFF;
            amount_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    ntoh_pkg::REG_STYLE:  style_reg  <= cfg_wdata[1:0];
                    ntoh_pkg::REG_AMOUNT: amount_reg <= cfg_wdata;
                    default:              style_reg  <= style_reg;
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        hum_reg      <= hum_next;
        odd_reg      <= odd_next;
        period_reg   <= period_next;
        acc_reg      <= acc_next;
        cnt_reg      <= cnt_next;
        sigma_reg    <= sigma_next;
        sum_reg      <= sum_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ===== rtl/ntoh_checker.sv =====
// Port-level checks for the note timing offset humaniser, bound to the top level.
module ntoh_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // Only one item is worked on at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again directly after an accept");

    // Even the quickest item passes through the output state before its result is loaded.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !$rose(m_tvalid))
        else $error("result appeared in the cycle after the accept");

    // The padding bit above the offset is always clear.
    a_pad_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !m_tdata[15])
        else $error("padding bit of m_tdata set");

    // A stalled result holds its value.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed or was dropped");

endmodule

bind note_timing_offset_humanizer_core ntoh_checker u_ntoh_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== dv/tb_note_timing_offset_humanizer_core.sv =====
// Self-checking testbench for the note timing offset humaniser core.
`timescale 1ns / 100ps

module tb_note_timing_offset_humanizer_core;

    // The style register is two bits wide, so code 3 can be written even
    // though it has no name in the package. It must behave as off.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int     HUMAN_SCALE = 26;
    localparam int     SIGMA_DIV   = 1000;
    localparam longint SWING_SCALE = 17;
    localparam longint SWING_DIV   = 100000;

    localparam int RESET_CYCLES   = 12;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 42;
    localparam int MAX_REPORTS    = 40;

    // Scoreboard: keeps its own copy of the registers and the LFSR, works out
    // the offset for every accepted step and checks results in order.
    class offset_scoreboard;
        logic [1:0]  style;
        logic [9:0]  amount;
        logic [15:0] lfsr;
        logic [14:0] expected_offsets[$];
        int          errors;

        function new();
            style  = ntoh_pkg::MODE_OFF;
            amount = '0;
            lfsr   = ntoh_pkg::LFSR_SEED;
            errors = 0;
        endfunction

        function void write_reg(logic index, logic [9:0] value);
            if (index == ntoh_pkg::REG_STYLE)
                style = value[1:0];
            else
                amount = value;
        endfunction

        // One Galois step, right shift, taps applied when a one falls out.
        function logic [7:0] draw_byte();
            logic lsb;
            lsb  = lfsr[0];
            lfsr = lfsr >> 1;
            if (lsb)
                lfsr = lfsr ^ ntoh_pkg::LFSR_TAPS;
            return lfsr[7:0];
        endfunction

        function void note_step(logic odd, logic [15:0] period);
            int     sigma;
            int     jitter_sum;
            int     offset;
            int     i;
            longint magnitude;
            offset = 0;
            if (amount >= ntoh_pkg::AMOUNT_MIN)
            begin
                if (style == ntoh_pkg::MODE_HUMAN)
                begin
                    sigma = int'(amount) * HUMAN_SCALE / SIGMA_DIV;
                    // With sigma zero the LFSR is left alone.
                    if (sigma >= 1)
                    begin
                        jitter_sum = 0;
                        for (i = 0; i < 4; i++)
                            jitter_sum += int'(draw_byte()) - 128;
                        // SystemVerilog division truncates toward zero.
                        offset = jitter_sum * sigma / 512;
                    end
                end
                else if (style == ntoh_pkg::MODE_SWING)
                begin
                    magnitude = longint'(period) * longint'(amount)
                                * SWING_SCALE / SWING_DIV;
                    offset = odd ? -int'(magnitude) : int'(magnitude);
                end
            end
            expected_offsets.push_back(offset[14:0]);
        endfunction

        function void check_offset(logic [15:0] data);
            logic [15:0] want;
            if (expected_offsets.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result with no step pending: expected none, actual %h",
                             $time, data);
                return;
            end
            want = {1'b0, expected_offsets.pop_front()};
            if (data !== want)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: offset mismatch: expected %0d (%h), actual %0d (%h)",
                             $time, $signed(want[14:0]), want, $signed(data[14:0]), data);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        cfg_we;
    logic        cfg_index;
    logic [9:0]  cfg_wdata;

    logic        hold_req;
    int          idle_cycles;

    offset_scoreboard sb;

    note_timing_offset_humanizer_core u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Monitor. Inputs only move on the falling edge, so everything sampled
    // here is settled. Register writes, accepted steps and accepted results
    // all go to the scoreboard in the order the block sees them. The same
    // block keeps the watchdog count: any cycle with no handshake and no
    // write adds one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.write_reg(cfg_index, cfg_wdata);
            if (s_tvalid && s_tready)
                sb.note_step(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_offset(m_tdata);
            if (cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, idle_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Receiver. It stalls on patterns of its own choosing, each lasting a
    // random number of cycles: always ready, coin toss, mostly ready or
    // mostly stalled. On request it holds off for a long stretch so that the
    // output register and the item in flight both back up and the block
    // drops s_tready while the sender keeps offering.
    initial
    begin
        int pattern;
        int pattern_left;
        pattern      = 0;
        pattern_left = 0;
        m_tready     = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    pattern      = $urandom_range(0, 3);
                    pattern_left = $urandom_range(10, 80);
                end
                case (pattern)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= ($urandom_range(0, 7) == 0);
                endcase
                pattern_left--;
            end
        end
    end

    // All driving tasks are entered and left on a falling edge.
    task automatic send_step(input logic odd, input logic [15:0] period);
        s_tvalid <= 1'b1;
        s_tdata  <= period;
        s_tuser  <= odd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    // Stop offering and wait until every pending offset has come back.
    // Each step gives exactly one result, so nothing is in flight after that.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (sb.expected_offsets.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic index, input logic [9:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // The upper bits of a style write are random: the block must mask them.
    task automatic set_mode(input logic [1:0] style, input logic [9:0] amount);
        drain_results();
        write_reg(ntoh_pkg::REG_STYLE, {8'($urandom), style});
        write_reg(ntoh_pkg::REG_AMOUNT, amount);
    endtask

    // Random steps in bursts with gaps between them; about a third of the
    // bursts run straight into the next one with no gap at all.
    task automatic run_random_steps(input int count);
        int          sent;
        int          burst;
        logic [15:0] period;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 16);
            repeat (burst)
            begin
                case ($urandom_range(0, 7))
                    0:       period = 16'h0000;
                    1:       period = 16'hFFFF;
                    default: period = 16'($urandom);
                endcase
                send_step(1'($urandom_range(0, 1)), period);
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
                pause_sender($urandom_range(1, 8));
        end
    endtask

    initial
    begin
        logic [1:0] style;
        logic [9:0] amount;
        int         phase;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = ntoh_pkg::REG_STYLE;
        cfg_wdata   = '0;
        hold_req    = 1'b0;
        idle_cycles = 0;
        rst_n       = 1'b0;
        sb          = new();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part. Straight after reset the style is off and the
        // amount is zero, so the extremes of the period must give zero.
        send_step(1'b0, 16'h0000);
        send_step(1'b1, 16'hFFFF);

        // Style off with full amount, and the unnamed style code.
        set_mode(ntoh_pkg::MODE_OFF, 10'd1000);
        send_step(1'b0, 16'hFFFF);
        set_mode(MODE_SPARE, 10'd500);
        send_step(1'b1, 16'h8000);

        // Human style: just below the threshold, at the threshold with sigma
        // still zero, the last amount with sigma zero, the first with sigma
        // one, full amount and the top of the register range.
        set_mode(ntoh_pkg::MODE_HUMAN, 10'd9);
        send_step(1'b0, 16'h1234);
        set_mode(ntoh_pkg::MODE_HUMAN, 10'd10);
        send_step(1'b1, 16'h1234);
        set_mode(ntoh_pkg::MODE_HUMAN, 10'd38);
        send_step(1'b0, 16'h0001);
        set_mode(ntoh_pkg::MODE_HUMAN, 10'd39);
        send_step(1'b0, 16'h0001);
        send_step(1'b1, 16'hFFFF);
        set_mode(ntoh_pkg::MODE_HUMAN, 10'd1000);
        send_step(1'b0, 16'h0000);
        send_step(1'b1, 16'hFFFF);
        send_step(1'b0, 16'h5555);
        set_mode(ntoh_pkg::MODE_HUMAN, 10'd1023);
        send_step(1'b1, 16'hAAAA);
        send_step(1'b0, 16'hFFFF);

        // Swing style: below threshold, at threshold, full amount on both
        // parities with the longest and shortest periods, and the top of
        // the amount range where the magnitude is largest.
        set_mode(ntoh_pkg::MODE_SWING, 10'd9);
        send_step(1'b0, 16'hFFFF);
        set_mode(ntoh_pkg::MODE_SWING, 10'd10);
        send_step(1'b0, 16'hFFFF);
        send_step(1'b1, 16'hFFFF);
        set_mode(ntoh_pkg::MODE_SWING, 10'd1000);
        send_step(1'b0, 16'hFFFF);
        send_step(1'b1, 16'hFFFF);
        send_step(1'b1, 16'h0000);
        send_step(1'b0, 16'h0001);
        set_mode(ntoh_pkg::MODE_SWING, 10'd1023);
        send_step(1'b0, 16'hFFFF);
        send_step(1'b1, 16'hFFFF);

        // Random part: each phase picks a style and an amount, waits for the
        // block to empty, writes both registers and sends a run of steps.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: style = ntoh_pkg::MODE_HUMAN;
                4, 5, 6, 7: style = ntoh_pkg::MODE_SWING;
                8:          style = ntoh_pkg::MODE_OFF;
                default:    style = MODE_SPARE;
            endcase
            case ($urandom_range(0, 7))
                0:       amount = 10'($urandom_range(0, 9));
                1:       amount = 10'($urandom_range(10, 38));
                2:       amount = 10'd1000;
                3:       amount = 10'd1023;
                default: amount = 10'($urandom_range(39, 1023));
            endcase
            set_mode(style, amount);
            // Ask for the long receiver hold-off once, early in the run.
            if (phase == 3)
                hold_req = 1'b1;
            run_random_steps(PHASE_ITEMS);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.expected_offsets.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            if (sb.expected_offsets.size() != 0)
                $display("%0t: %0d offsets never arrived: expected 0 pending, actual %0d",
                         $time, sb.expected_offsets.size(), sb.expected_offsets.size());
            $display("FAILURE");
        end
        $finish;
    end

endmodule
